// ===== src/fbds_pkg.sv =====
// fbds_pkg: shared widths, constants, sequencer states and result record
// for the fractional baud divisor search core
// depends on nothing
`default_nettype none

package fbds_pkg;

    localparam int CLK_W   = 25;
    localparam int BAUD_W  = 20;
    localparam int F_W     = 20;
    localparam int DL_W    = 16;
    localparam int N_W     = 11;
    localparam int MC_W    = 2;
    localparam int M_W     = 3;
    localparam int DIV_W   = 32;
    localparam int DSR_W   = 20;
    localparam int WIDE_W  = 31;
    localparam int MN_W    = 14;
    localparam int CNT_W   = $clog2(DIV_W);

    localparam logic [CLK_W-1:0] CLK_RESET  = 25'd10240000;
    localparam logic [DL_W-1:0]  DL_LIMIT   = 16'hffff;
    localparam logic [N_W-1:0]   FRAC_LIMIT = 11'd2047;
    localparam logic [M_W-1:0]   M_FIRST    = 3'd1;
    localparam logic [M_W-1:0]   M_LAST     = 3'd4;
    localparam logic [M_W-1:0]   MC_MASK    = 3'h3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L_Q,
        ST_G_Q,
        ST_L_P,
        ST_G_P,
        ST_L_LO,
        ST_G_LO,
        ST_L_HI,
        ST_G_HI,
        ST_DL_CHK,
        ST_L_PDL,
        ST_G_PDL,
        ST_L_RDL,
        ST_G_RDL,
        ST_L_RN,
        ST_G_RN,
        ST_CMP,
        ST_NEXT_DL,
        ST_NEXT_M,
        ST_WAIT,
        ST_DONE
    } fbds_state_t;

    typedef struct packed {
        logic [DL_W-1:0]  dl;
        logic [MC_W-1:0]  mult;
        logic [N_W-1:0]   n;
        logic [CLK_W-1:0] err;
        logic             found;
    } fbds_result_t;

endpackage

`default_nettype wire

// ===== src/fbds_div.sv =====
// fbds_div: bit-serial restoring divider, one quotient bit per cycle
// uses fbds_pkg for operand widths
`default_nettype none

module fbds_div
    import fbds_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   work_reg, work_next;
    logic [DSR_W:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]   dsr_reg, dsr_next;
    logic [DSR_W:0]     rem_sh;
    logic               ge;

    // shift the next dividend bit into the partial remainder
    assign rem_sh = {rem_reg[DSR_W-1:0], work_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            work_next = {work_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

// ===== src/fbds_search.sv =====
// fbds_search: sequencer that walks multiplier, divisor and fraction windows
// and keeps the best candidate; uses fbds_pkg and one shared fbds_div
`default_nettype none

module fbds_search
    import fbds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [BAUD_W-1:0] baud,
    input  wire logic [CLK_W-1:0]  core_clk,
    input  wire logic              res_take,
    output logic                   idle,
    output logic                   res_valid,
    output fbds_result_t           res
);

    fbds_state_t state_reg, state_next;
    fbds_state_t ret_reg, ret_sel;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DSR_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  quo;

    logic [BAUD_W-1:0] baud_reg;
    logic [F_W-1:0]    f_reg;
    logic [F_W-1:0]    q_reg;
    logic [WIDE_W-1:0] p_reg;
    logic [WIDE_W-1:0] r_reg;
    logic [F_W-1:0]    lo_reg;
    logic [DL_W-1:0]   hi_reg;
    logic [DL_W-1:0]   dl_reg;
    logic [M_W-1:0]    m_reg;
    logic [N_W-1:0]    n_reg;
    logic [N_W-1:0]    n_last_reg;
    logic [WIDE_W-1:0] err_reg;
    logic [CLK_W-1:0]  best_err_reg;
    logic [DL_W-1:0]   best_dl_reg;
    logic [MC_W-1:0]   best_m_reg;
    logic [N_W-1:0]    best_n_reg;
    logic              hit_reg;

    logic [WIDE_W-1:0] f_big;
    logic [F_W:0]      hi_raw;
    logic [DL_W-1:0]   hi_clamp;
    logic              in_win;
    logic [N_W-1:0]    ideal;
    logic [MN_W-1:0]   mn;
    logic [WIDE_W-1:0] rate;
    logic [WIDE_W-1:0] baud_wide;
    logic [M_W-1:0]    m_plus;

    fbds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign f_big     = {f_reg, 11'b0};
    assign hi_raw    = {1'b0, quo[F_W-1:0]} + 1'b1;
    assign hi_clamp  = (hi_raw > {{(F_W+1-DL_W){1'b0}}, DL_LIMIT}) ? DL_LIMIT : hi_raw[DL_W-1:0];
    // ideal fraction lies in the window exactly when the quotient's upper part equals m
    assign in_win    = quo[WIDE_W-1:N_W] == {{(WIDE_W-N_W-M_W){1'b0}}, m_reg};
    assign ideal     = quo[N_W-1:0];
    assign mn        = {m_reg, {N_W{1'b0}}} + {{(MN_W-N_W){1'b0}}, n_reg};
    assign rate      = quo[WIDE_W-1:0];
    assign baud_wide = {{(WIDE_W-BAUD_W){1'b0}}, baud_reg};
    assign m_plus    = m_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = (baud == '0) ? ST_DONE : ST_L_Q;
            end
            ST_L_Q, ST_L_P, ST_L_LO, ST_L_HI, ST_L_PDL, ST_L_RDL, ST_L_RN:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_done)
                    state_next = ret_reg;
            end
            ST_G_Q:  state_next = ST_L_P;
            ST_G_P:  state_next = ST_L_LO;
            ST_G_LO: state_next = ST_L_HI;
            ST_G_HI:
                state_next = (lo_reg < {{(F_W-DL_W){1'b0}}, hi_clamp}) ? ST_DL_CHK : ST_NEXT_M;
            ST_DL_CHK:
                state_next = (dl_reg == '0) ? ST_NEXT_DL : ST_L_PDL;
            ST_G_PDL:
                state_next = in_win ? ST_L_RDL : ST_NEXT_DL;
            ST_G_RDL: state_next = ST_L_RN;
            ST_G_RN:  state_next = ST_CMP;
            ST_CMP:
                state_next = (n_reg == n_last_reg) ? ST_NEXT_DL : ST_L_RN;
            ST_NEXT_DL:
                state_next = (({1'b0, dl_reg} + 1'b1) < {1'b0, hi_reg}) ? ST_DL_CHK : ST_NEXT_M;
            ST_NEXT_M:
                state_next = (m_reg == M_LAST) ? ST_DONE : ST_L_LO;
            ST_DONE:
            begin
                if (res_take)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // divider launch outputs
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        ret_sel      = ST_IDLE;
        case (state_reg)
            ST_L_Q:
            begin
                div_start    = 1'b1;
                div_dividend = {{(DIV_W-F_W){1'b0}}, f_reg};
                div_divisor  = baud_reg;
                ret_sel      = ST_G_Q;
            end
            ST_L_P:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, f_big};
                div_divisor  = baud_reg;
                ret_sel      = ST_G_P;
            end
            ST_L_LO:
            begin
                div_start    = 1'b1;
                div_dividend = {{(DIV_W-F_W){1'b0}}, q_reg};
                div_divisor  = {{(DSR_W-M_W){1'b0}}, m_plus};
                ret_sel      = ST_G_LO;
            end
            ST_L_HI:
            begin
                div_start    = 1'b1;
                div_dividend = {{(DIV_W-F_W){1'b0}}, q_reg};
                div_divisor  = {{(DSR_W-M_W){1'b0}}, m_reg};
                ret_sel      = ST_G_HI;
            end
            ST_L_PDL:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, p_reg};
                div_divisor  = {{(DSR_W-DL_W){1'b0}}, dl_reg};
                ret_sel      = ST_G_PDL;
            end
            ST_L_RDL:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, f_big};
                div_divisor  = {{(DSR_W-DL_W){1'b0}}, dl_reg};
                ret_sel      = ST_G_RDL;
            end
            ST_L_RN:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, r_reg};
                div_divisor  = {{(DSR_W-MN_W){1'b0}}, mn};
                ret_sel      = ST_G_RN;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
                ret_reg <= ret_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    baud_reg     <= baud;
                    f_reg        <= core_clk[CLK_W-1:CLK_W-F_W];
                    best_err_reg <= core_clk;
                    best_dl_reg  <= '0;
                    best_m_reg   <= '0;
                    best_n_reg   <= '0;
                    hit_reg      <= 1'b0;
                    m_reg        <= M_FIRST;
                end
            end
            ST_G_Q: q_reg <= quo[F_W-1:0];
            ST_G_P: p_reg <= quo[WIDE_W-1:0];
            ST_G_LO:
                lo_reg <= (quo[F_W-1:0] == '0) ? '0 : quo[F_W-1:0] - 1'b1;
            ST_G_HI:
            begin
                hi_reg <= hi_clamp;
                dl_reg <= lo_reg[DL_W-1:0];
            end
            ST_G_PDL:
            begin
                n_reg      <= (ideal == '0) ? '0 : ideal - 1'b1;
                // top fraction is never tried
                n_last_reg <= (ideal == FRAC_LIMIT) ? FRAC_LIMIT - 1'b1 : ideal;
            end
            ST_G_RDL: r_reg <= quo[WIDE_W-1:0];
            ST_G_RN:
                err_reg <= (rate >= baud_wide) ? rate - baud_wide : baud_wide - rate;
            ST_CMP:
            begin
                if (err_reg < {{(WIDE_W-CLK_W){1'b0}}, best_err_reg})
                begin
                    best_err_reg <= err_reg[CLK_W-1:0];
                    best_dl_reg  <= dl_reg;
                    best_m_reg   <= m_reg[MC_W-1:0] & MC_MASK[MC_W-1:0];
                    best_n_reg   <= n_reg;
                    hit_reg      <= 1'b1;
                end
                if (n_reg != n_last_reg)
                    n_reg <= n_reg + 1'b1;
            end
            ST_NEXT_DL: dl_reg <= dl_reg + 1'b1;
            ST_NEXT_M:  m_reg  <= m_reg + 1'b1;
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    assign idle      = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res.dl    = best_dl_reg;
    assign res.mult  = best_m_reg;
    assign res.n     = best_n_reg;
    assign res.err   = best_err_reg;
    assign res.found = hit_reg;

endmodule

`default_nettype wire

// ===== src/fractional_baud_divisor_search_core.sv =====
// fractional_baud_divisor_search_core: top level with clock register,
// input handshake and result register; uses fbds_pkg and fbds_search
//
// usage: write the core clock in hertz through cfg_wr_en / cfg_wr_data while
// the block is idle; reset loads 10240000. present a requested baud_rate on
// in_valid; the transfer happens when in_valid is high and in_stall is low.
// one result comes back per request on out_valid with divisor_latch,
// mult_code (multiplier 4 reads as 0), frac_n, rate_error and found.
// every candidate step uses the one shared bit-serial divider, with a launch
// state, a wait state and a collect state around each division; a zero baud
// rate skips the search and goes straight to the result.
// one request is searched at a time; in_stall is high while a search runs.
// a finished result sits in the output register until taken, and the next
// request can be accepted meanwhile; while out_stall holds a result and a
// second search finishes, that search waits before taking further requests.
// reset clears the sequencer and the output valid; no memory clearing pass.
`default_nettype none

module fractional_baud_divisor_search_core
    import fbds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CLK_W-1:0]  cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BAUD_W-1:0] baud_rate,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DL_W-1:0]        divisor_latch,
    output logic [MC_W-1:0]        mult_code,
    output logic [N_W-1:0]         frac_n,
    output logic [CLK_W-1:0]       rate_error,
    output logic                   found
);

    logic [CLK_W-1:0] clk_hz_reg;
    logic             out_valid_reg, out_valid_next;
    fbds_result_t     out_reg;
    fbds_result_t     res;
    logic             srch_idle;
    logic             res_valid;
    logic             out_free;
    logic             res_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign res_take = res_valid && out_free;
    assign in_stall = !srch_idle;

    fbds_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && srch_idle),
        .baud      (baud_rate),
        .core_clk  (clk_hz_reg),
        .res_take  (res_take),
        .idle      (srch_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg    <= CLK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                clk_hz_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign divisor_latch = out_reg.dl;
    assign mult_code     = out_reg.mult;
    assign frac_n        = out_reg.n;
    assign rate_error    = out_reg.err;
    assign found         = out_reg.found;

    // an accepted request always starts the sequencer
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !srch_idle)
        else $error("accepted request did not start a search");

    // nothing found leaves the setting at zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |->
            (divisor_latch == '0 && mult_code == '0 && frac_n == '0))
        else $error("miss result carries a nonzero setting");

    // a hit never uses a zero divisor or the top fraction
    a_hit_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (divisor_latch != '0 && frac_n != FRAC_LIMIT))
        else $error("hit result carries an illegal setting");

endmodule

`default_nettype wire

// ===== tb/sv/tb_fractional_baud_divisor_search_core.sv =====
`timescale 1ns / 1ps
// tb_fractional_baud_divisor_search_core: self-checking bench for the baud divisor search core
// drives requested rates and clock settings, predicts each divider choice and checks it
// depends on fbds_pkg and fractional_baud_divisor_search_core

module tb_fractional_baud_divisor_search_core
    import fbds_pkg::*;
();

    localparam longint FRAC_ONE = 2048;
    localparam logic [CLK_W-1:0] CLK_MIN = 25'd1000000;
    localparam logic [CLK_W-1:0] CLK_MAX = 25'h1ffffff;
    localparam logic [BAUD_W-1:0] BAUD_MAX = 20'hfffff;

    typedef struct packed {
        logic [CLK_W-1:0]  clk_hz;
        logic [BAUD_W-1:0] baud;
        logic              fixed_want;
        fbds_result_t      want;
    } vector_t;

    // rows with fixed_want set carry a result readable at a glance:
    // nothing found (error equals the clock) or an exact hit at dl 1, m 1, n 0
    localparam vector_t DIRECTED [20] = '{
        {CLK_RESET, 20'd0,       1'b1, 16'd0, 2'd0, 11'd0, CLK_RESET, 1'b0},
        {CLK_RESET, BAUD_MAX,    1'b1, 16'd0, 2'd0, 11'd0, CLK_RESET, 1'b0},
        {CLK_RESET, 20'd320000,  1'b1, 16'd1, 2'd1, 11'd0, 25'd0, 1'b1},
        {CLK_RESET, 20'd160039,  1'b0, 55'd0},
        {CLK_RESET, 20'd115200,  1'b0, 55'd0},
        {CLK_RESET, 20'd57600,   1'b0, 55'd0},
        {CLK_RESET, 20'd19200,   1'b0, 55'd0},
        {CLK_RESET, 20'd9600,    1'b0, 55'd0},
        {CLK_RESET, 20'd300000,  1'b0, 55'd0},
        {CLK_MAX,   20'd1,       1'b1, 16'd0, 2'd0, 11'd0, CLK_MAX, 1'b0},
        {CLK_MAX,   BAUD_MAX,    1'b1, 16'd1, 2'd1, 11'd0, 25'd0, 1'b1},
        {CLK_MAX,   20'd0,       1'b1, 16'd0, 2'd0, 11'd0, CLK_MAX, 1'b0},
        {CLK_MAX,   20'd921600,  1'b0, 55'd0},
        {CLK_MAX,   20'd524288,  1'b0, 55'd0},
        {CLK_MIN,   20'd31250,   1'b1, 16'd1, 2'd1, 11'd0, 25'd0, 1'b1},
        {CLK_MIN,   20'd31249,   1'b0, 55'd0},
        {CLK_MIN,   20'd15625,   1'b0, 55'd0},
        {CLK_MIN,   BAUD_MAX,    1'b1, 16'd0, 2'd0, 11'd0, CLK_MIN, 1'b0},
        {CLK_MIN,   20'd3000,    1'b0, 55'd0},
        {CLK_MIN,   20'd0,       1'b1, 16'd0, 2'd0, 11'd0, CLK_MIN, 1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CLK_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [BAUD_W-1:0] baud_rate;
    logic              out_valid;
    logic              out_stall;
    logic [DL_W-1:0]   divisor_latch;
    logic [MC_W-1:0]   mult_code;
    logic [N_W-1:0]    frac_n;
    logic [CLK_W-1:0]  rate_error;
    logic              found;

    fbds_result_t      expected_settings_q [$];
    logic [CLK_W-1:0]  clock_hz;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                mismatch_count;
    longint            cycle_count;
    longint            cycle_budget;

    fractional_baud_divisor_search_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .baud_rate     (baud_rate),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .divisor_latch (divisor_latch),
        .mult_code     (mult_code),
        .frac_n        (frac_n),
        .rate_error    (rate_error),
        .found         (found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // walks every multiplier, divisor and fraction window; steps counts the work done
    function automatic fbds_result_t search_divisor(input logic [CLK_W-1:0] clk_hz,
                                                    input logic [BAUD_W-1:0] baud,
                                                    output longint steps);
        longint b, f, best_err, best_dl, best_m, best_n;
        longint m, dl, n, dl_lo, dl_hi, ideal, n_lo, n_hi, rate, err;
        fbds_result_t res;
        b = longint'(baud);
        f = longint'(clk_hz) / 32;
        best_err = longint'(clk_hz);
        best_dl = 0;
        best_m = 0;
        best_n = 0;
        res.found = 1'b0;
        steps = 10;
        if (b != 0)
        begin
            for (m = 1; m <= 4; m++)
            begin
                dl_lo = f / b / (m + 1) - 1;
                dl_hi = f / b / m + 1;
                if (dl_lo < 0)
                    dl_lo = 0;
                if (dl_hi > longint'(DL_LIMIT))
                    dl_hi = longint'(DL_LIMIT);
                for (dl = dl_lo; dl < dl_hi; dl++)
                begin
                    steps += 2;
                    if (dl == 0)
                        continue;
                    ideal = f * FRAC_ONE / b / dl - m * FRAC_ONE;
                    n_lo = ideal - 1;
                    n_hi = ideal + 1;
                    if (n_lo < 0)
                        n_lo = 0;
                    if (n_hi > longint'(FRAC_LIMIT))
                        n_hi = longint'(FRAC_LIMIT);
                    for (n = n_lo; n < n_hi; n++)
                    begin
                        steps++;
                        rate = f * FRAC_ONE / dl / (m * FRAC_ONE + n);
                        err = rate - b;
                        if (err < 0)
                            err = -err;
                        if (err < best_err)
                        begin
                            best_err = err;
                            best_dl = dl;
                            best_m = m & 3;
                            best_n = n;
                            res.found = 1'b1;
                        end
                    end
                end
            end
        end
        res.dl = best_dl[DL_W-1:0];
        res.mult = best_m[MC_W-1:0];
        res.n = best_n[N_W-1:0];
        res.err = best_err[CLK_W-1:0];
        return res;
    endfunction

    // mostly small clock-to-rate ratios so each search stays short
    function automatic logic [BAUD_W-1:0] pick_baud(input logic [CLK_W-1:0] clk_hz);
        longint f, r;
        int sel;
        f = longint'(clk_hz) / 32;
        sel = $urandom_range(99);
        if (sel < 5)
            return '0;
        if (sel < 15 && f < longint'(BAUD_MAX))
            return BAUD_W'($urandom_range(BAUD_MAX, 32'(f + 1)));
        r = (sel < 25) ? longint'($urandom_range(80, 25)) : longint'($urandom_range(24, 1));
        return BAUD_W'($urandom_range(32'(f / r), 32'(f / (r + 1) + 1)));
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic transfer_request(input logic [BAUD_W-1:0] b, input logic use_fixed,
                                    input fbds_result_t fixed);
        fbds_result_t pred;
        longint steps;
        in_valid <= 1'b1;
        baud_rate <= b;
        do
            @(posedge clk);
        while (in_stall);
        pred = search_divisor(clock_hz, b, steps);
        expected_settings_q.push_back(use_fixed ? fixed : pred);
        cycle_budget += 4 * (40 * (steps + 12) + 400);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_settings_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic program_clock(input logic [CLK_W-1:0] hz);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        clock_hz = hz;
    endtask

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        fbds_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_settings_q.size() == 0)
                begin
                    $display("%0t unexpected result: dl %0d mult %0d n %0d err %0d found %0d",
                             $time, divisor_latch, mult_code, frac_n, rate_error, found);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_settings_q.pop_front();
                    check_field("divisor_latch", longint'(want.dl), longint'(divisor_latch));
                    check_field("mult_code", longint'(want.mult), longint'(mult_code));
                    check_field("frac_n", longint'(want.n), longint'(frac_n));
                    check_field("rate_error", longint'(want.err), longint'(rate_error));
                    check_field("found", longint'(want.found), longint'(found));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_budget)
        begin
            $display("FAIL fractional_baud_divisor_search_core");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        baud_rate = '0;
        out_stall = 1'b0;
        clock_hz = CLK_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count = 0;
        cycle_budget = 300000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].clk_hz != clock_hz)
            begin
                wait_drained();
                program_clock(DIRECTED[i].clk_hz);
            end
            transfer_request(DIRECTED[i].baud, DIRECTED[i].fixed_want, DIRECTED[i].want);
        end

        // idling phases: none, sender only, receiver only, both
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            program_clock(CLK_W'($urandom_range(CLK_MAX, CLK_MIN)));
            send_idle_pct = (phase == 1) ? 50 : (phase == 3) ? 21 : 0;
            recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 21 : 0;
            for (int i = 0; i < 20; i++)
            begin
                if (i == 10)
                    wait_drained();
                transfer_request(pick_baud(clock_hz), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (500) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS fractional_baud_divisor_search_core");
        else
            $display("FAIL fractional_baud_divisor_search_core");
        $finish;
    end

endmodule
